// ----- hw/rtl/agcl_pkg.sv -----
// ----------------------------------------------------------------------------
// agcl_pkg
// Shared types, codes and microcode store for the adaptive gain control law.
// ----------------------------------------------------------------------------
package agcl_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int DECAY_W    = 16;
  localparam int MAXERR_W   = 23;
  localparam int OPND_W     = DATA_W + 1;        // shared multiplier operand
  localparam int PROD_W     = 2 * OPND_W;
  localparam int ACC_W      = PROD_W;
  localparam int BAND_W     = 55;                // 100*|e| << 16 and band product
  localparam int PCT_W      = DATA_W + 7;
  localparam int REM_W      = ACC_W - (DATA_W - 1);
  localparam int QUOT_W     = DATA_W - 1;
  localparam int CNT_W      = 5;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MAXERR_W;

  localparam logic [CNT_W-1:0] DIV_STEPS_M1 = CNT_W'(QUOT_W - 1);

  localparam logic signed [DATA_W-1:0] LEVEL_RESET = 32'sd458752;   // 7.0
  localparam logic signed [DATA_W-1:0] GAIN_RESET  = 32'sd65536;    // 1.0
  localparam logic signed [DATA_W-1:0] GAIN_NONE   = -32'sd65536;   // -1.0
  localparam logic [DECAY_W-1:0]       DECAY_RESET  = 16'd46958;
  localparam logic [MAXERR_W-1:0]      MAXERR_RESET = 23'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXERR = 2'd1;

  typedef enum logic [1:0] {
    FUNC_OUTPUT    = 2'd0,
    FUNC_REFERENCE = 2'd1,
    FUNC_ERROR     = 2'd2,
    FUNC_ESTIMATE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_STEADY   = 2'd1,
    ST_NEW_GAIN = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_BAND, MUL_DECAY, MUL_A1D, MUL_A2Y, MUL_A3P
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    DP_NONE, DP_DIFF, DP_DIV_INIT, DP_DIV_STEP, DP_SAT
  } dp_op_t;

  typedef enum logic [2:0] {
    BR_NEXT, BR_STEADY, BR_OVF, BR_LOOP, BR_JUMP
  } br_op_t;

  typedef enum logic [1:0] {
    END_NONE, END_GAIN, END_STEADY
  } end_op_t;

  typedef struct packed {
    mul_op_t         mul;
    acc_op_t         acc;
    dp_op_t          dp;
    br_op_t          br;
    end_op_t         fin;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] UPC_BAND     = 4'd0;
  localparam logic [PC_W-1:0] UPC_TEST     = 4'd1;
  localparam logic [PC_W-1:0] UPC_DECAY    = 4'd2;
  localparam logic [PC_W-1:0] UPC_DIFF     = 4'd3;
  localparam logic [PC_W-1:0] UPC_A1D      = 4'd4;
  localparam logic [PC_W-1:0] UPC_A2Y      = 4'd5;
  localparam logic [PC_W-1:0] UPC_A3P      = 4'd6;
  localparam logic [PC_W-1:0] UPC_SUM      = 4'd7;
  localparam logic [PC_W-1:0] UPC_DIV_INIT = 4'd8;
  localparam logic [PC_W-1:0] UPC_OVF      = 4'd9;
  localparam logic [PC_W-1:0] UPC_DIV_LOOP = 4'd10;
  localparam logic [PC_W-1:0] UPC_GAIN_END = 4'd11;
  localparam logic [PC_W-1:0] UPC_STEADY   = 4'd12;
  localparam logic [PC_W-1:0] UPC_SAT      = 4'd13;

  // Microprogram of the gain rule.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{mul: MUL_NONE, acc: ACC_NONE, dp: DP_NONE, br: BR_NEXT,
          fin: END_NONE, target: UPC_BAND};
    unique case (pc)
      UPC_BAND:     w.mul = MUL_BAND;
      UPC_TEST: begin
        w.br     = BR_STEADY;
        w.target = UPC_STEADY;
      end
      UPC_DECAY:    w.mul = MUL_DECAY;
      UPC_DIFF:     w.dp  = DP_DIFF;
      UPC_A1D:      w.mul = MUL_A1D;
      UPC_A2Y: begin
        w.acc = ACC_LOAD;
        w.mul = MUL_A2Y;
      end
      UPC_A3P: begin
        w.acc = ACC_ADD;
        w.mul = MUL_A3P;
      end
      UPC_SUM:      w.acc = ACC_ADD;
      UPC_DIV_INIT: w.dp  = DP_DIV_INIT;
      UPC_OVF: begin
        w.br     = BR_OVF;
        w.target = UPC_SAT;
      end
      UPC_DIV_LOOP: begin
        w.dp     = DP_DIV_STEP;
        w.br     = BR_LOOP;
        w.target = UPC_DIV_LOOP;
      end
      UPC_GAIN_END: w.fin = END_GAIN;
      UPC_STEADY:   w.fin = END_STEADY;
      UPC_SAT: begin
        w.dp     = DP_SAT;
        w.br     = BR_JUMP;
        w.target = UPC_GAIN_END;
      end
      default:      w.fin = END_GAIN;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/adaptive_gain_control_law_core.sv -----
// ----------------------------------------------------------------------------
// adaptive_gain_control_law_core
// Adaptive regulator gain unit, Q16.16, driven by a small microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall) takes one message per beat: a plant
//   output sample, a reference, an error sample or a model estimate (func).
//   Every beat yields exactly one result beat on res_valid/res_stall carrying
//   the current gain, its valid mark and a status code.
//   cfg channel (cfg_valid/cfg_ready) writes decay_factor (index 0) and
//   max_error_pct (index 1); write only while the block is idle.
// Flow:
//   plain messages and error samples without a valid estimate go straight to
//   the result slot. An error sample inside the steady band ends after the
//   band test. A full gain update runs through the 31-step restoring divider
//   and the shared 33x33 multiplier used in five microprogram steps.
//   The next beat is taken the cycle after the result is loaded.
// Reset: synchronous; clears history to 7.0, coefficients to zero, gain 1.0
//   marked not valid, and empties the output register.
// Stall: a stalled result holds; one further beat is taken and finished
//   internally, then item_stall stays high until the result slot frees.
// ----------------------------------------------------------------------------
module adaptive_gain_control_law_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [1:0]                           func,
  input  logic signed [agcl_pkg::DATA_W-1:0]   sample_value,
  input  logic signed [agcl_pkg::DATA_W-1:0]   est_p1,
  input  logic signed [agcl_pkg::DATA_W-1:0]   est_p2,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic signed [agcl_pkg::DATA_W-1:0]   gain,
  output logic                                 gain_valid,
  output logic [1:0]                           status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [agcl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [agcl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import agcl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_POST} state_t;

  state_t                    state;
  logic [PC_W-1:0]           pc;
  uword_t                    uw;

  logic signed [DATA_W-1:0]  ref_q, out_now, out_prev, err_q;
  logic signed [DATA_W-1:0]  coef1, coef2, coef3, gain_q;
  logic                      est_ok, reg_ok;
  logic [DECAY_W-1:0]        decay_q;
  logic [MAXERR_W-1:0]       maxerr_q;
  status_t                   status_q;
  logic [1:0]                status_q_out;

  // datapath
  logic signed [OPND_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [OPND_W-1:0]  diff;
  logic signed [ACC_W-1:0]   acc;
  logic [REM_W-1:0]          rem;
  logic [QUOT_W-1:0]         quot;
  logic [CNT_W-1:0]          cnt;
  logic                      q_neg;

  logic [DATA_W-1:0]         ref_mag, err_mag;
  logic [ACC_W-1:0]          acc_mag;
  logic [PCT_W-1:0]          pct;
  logic [BAND_W-1:0]         band_lhs;
  logic                      steady, ovf;
  logic [DATA_W:0]           trial, trial_sub;
  logic                      trial_ge;
  logic [PC_W-1:0]           pc_next;
  logic signed [DATA_W:0]    sum1;
  logic signed [DATA_W+1:0]  sum2;
  logic signed [DATA_W-1:0]  coef1_next, coef2_next;
  logic                      item_take;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W+1:0] x);
    logic signed [DATA_W+1:0] hi, lo;
    hi = (DATA_W+2)'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - (DATA_W+2)'(1);
    if (x > hi)      return hi[DATA_W-1:0];
    else if (x < lo) return lo[DATA_W-1:0];
    else             return x[DATA_W-1:0];
  endfunction

  assign uw        = ucode_rom(pc);
  assign cfg_ready = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign status     = status_q_out;

  // coefficients from a new estimate
  assign sum1       = {est_p1[DATA_W-1], est_p1} + {est_p2[DATA_W-1], est_p2};
  assign sum2       = -({{2{est_p1[DATA_W-1]}}, est_p1} + {est_p2[DATA_W-1], est_p2, 1'b0});
  assign coef1_next = sat_data({sum1[DATA_W], sum1});
  assign coef2_next = sat_data(sum2);

  assign ref_mag  = ref_q[DATA_W-1] ? DATA_W'(-ref_q) : DATA_W'(ref_q);
  assign err_mag  = err_q[DATA_W-1] ? DATA_W'(-err_q) : DATA_W'(err_q);
  assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  // 100*|e| as shift-add, then into Q16.16 percent scale
  assign pct      = (PCT_W'(err_mag) << 6) + (PCT_W'(err_mag) << 5) + (PCT_W'(err_mag) << 2);
  assign band_lhs = {pct, {FRAC_W{1'b0}}};
  assign steady   = band_lhs <= prod[BAND_W-1:0];

  assign ovf       = rem >= REM_W'(err_mag);
  assign trial     = {rem[DATA_W-1:0], quot[QUOT_W-1]};
  assign trial_ge  = trial >= {1'b0, err_mag};
  assign trial_sub = trial - {1'b0, err_mag};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul)
      MUL_BAND: begin
        mul_a = OPND_W'(maxerr_q);
        mul_b = {1'b0, ref_mag};
      end
      MUL_DECAY: begin
        mul_a = {err_q[DATA_W-1], err_q};
        mul_b = OPND_W'(decay_q);
      end
      MUL_A1D: begin
        mul_a = {coef1[DATA_W-1], coef1};
        mul_b = diff;
      end
      MUL_A2Y: begin
        mul_a = {coef2[DATA_W-1], coef2};
        mul_b = {out_now[DATA_W-1], out_now};
      end
      MUL_A3P: begin
        mul_a = {coef3[DATA_W-1], coef3};
        mul_b = {out_prev[DATA_W-1], out_prev};
      end
      default: ;
    endcase
  end

  always_comb begin
    pc_next = pc + PC_W'(1);
    unique case (uw.br)
      BR_NEXT:   pc_next = pc + PC_W'(1);
      BR_STEADY: if (steady) pc_next = uw.target;
      BR_OVF:    if (ovf) pc_next = uw.target;
      BR_LOOP:   if (cnt != '0) pc_next = uw.target;
      BR_JUMP:   pc_next = uw.target;
      default:   pc_next = pc + PC_W'(1);
    endcase
  end

  // arithmetic datapath, no reset needed
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (uw.acc)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default:  ;
    endcase
    case (uw.dp)
      DP_DIFF: diff <= {ref_q[DATA_W-1], ref_q} -
                       {prod[DATA_W+FRAC_W-1], prod[DATA_W+FRAC_W-1:FRAC_W]};
      DP_DIV_INIT: begin
        rem   <= acc_mag[ACC_W-1:QUOT_W];
        quot  <= acc_mag[QUOT_W-1:0];
        cnt   <= DIV_STEPS_M1;
        q_neg <= acc[ACC_W-1] ^ err_q[DATA_W-1];
      end
      DP_DIV_STEP: begin
        rem  <= REM_W'(trial_ge ? trial_sub : trial);
        quot <= {quot[QUOT_W-2:0], trial_ge};
        cnt  <= cnt - CNT_W'(1);
      end
      DP_SAT:  quot <= '1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pc           <= UPC_BAND;
      ref_q        <= LEVEL_RESET;
      out_now      <= LEVEL_RESET;
      out_prev     <= LEVEL_RESET;
      err_q        <= '0;
      coef1        <= '0;
      coef2        <= '0;
      coef3        <= '0;
      est_ok       <= 1'b0;
      reg_ok       <= 1'b0;
      gain_q       <= GAIN_RESET;
      decay_q      <= DECAY_RESET;
      maxerr_q     <= MAXERR_RESET;
      status_q     <= ST_NONE;
      res_valid    <= 1'b0;
      gain         <= GAIN_NONE;
      gain_valid   <= 1'b0;
      status_q_out <= ST_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DECAY)  decay_q  <= cfg_data[DECAY_W-1:0];
        if (cfg_index == CFG_MAXERR) maxerr_q <= cfg_data;
      end

      // in S_POST the slot is reloaded instead
      if (res_valid && !res_stall && state != S_POST) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            status_q <= ST_NONE;
            state    <= S_POST;
            case (func_t'(func))
              FUNC_OUTPUT: begin
                out_prev <= out_now;
                out_now  <= sample_value;
              end
              FUNC_REFERENCE: ref_q <= sample_value;
              FUNC_ERROR: begin
                err_q <= sample_value;
                if (est_ok) begin
                  state <= S_RUN;
                  pc    <= UPC_BAND;
                end
              end
              default: begin
                coef1  <= coef1_next;
                coef2  <= coef2_next;
                coef3  <= est_p2;
                est_ok <= 1'b1;
              end
            endcase
          end
        end
        S_RUN: begin
          pc <= pc_next;
          case (uw.fin)
            END_STEADY: begin
              reg_ok   <= 1'b1;
              status_q <= ST_STEADY;
              state    <= S_POST;
            end
            END_GAIN: begin
              // negative quotient rejected; zero passes
              if (q_neg && quot != '0) begin
                reg_ok   <= 1'b0;
                status_q <= ST_REJECTED;
              end else begin
                gain_q   <= {1'b0, quot};
                reg_ok   <= 1'b1;
                status_q <= ST_NEW_GAIN;
              end
              state <= S_POST;
            end
            default: ;
          endcase
        end
        S_POST: begin
          if (!res_valid || !res_stall) begin
            res_valid    <= 1'b1;
            gain         <= reg_ok ? gain_q : GAIN_NONE;
            gain_valid   <= reg_ok;
            status_q_out <= status_q;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/agcl_checker.sv -----
// ----------------------------------------------------------------------------
// agcl_checker
// Port-level checks on the gain unit's item and result streams, bound to the top level.
// ----------------------------------------------------------------------------
module agcl_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_stall,
  input logic                               res_valid,
  input logic                               res_stall,
  input logic signed [agcl_pkg::DATA_W-1:0] gain,
  input logic                               gain_valid,
  input logic [1:0]                         status
);
  import agcl_pkg::*;

  // one message in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("beat accepted while previous message in flight");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(gain) && $stable(gain_valid)
                               && $stable(status))
    else $error("stalled result changed");

  a_invalid_gain: assert property (@(posedge clk) disable iff (rst)
    res_valid && !gain_valid |-> gain == GAIN_NONE)
    else $error("gain not minus one while not valid");

  a_kept_or_new: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_STEADY || status == ST_NEW_GAIN) |-> gain_valid && !gain[DATA_W-1])
    else $error("steady or new gain without valid non-negative gain");

  a_rejected: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_REJECTED |-> !gain_valid)
    else $error("rejected gain still marked valid");

endmodule

bind adaptive_gain_control_law_core agcl_checker u_agcl_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .gain       (gain),
  .gain_valid (gain_valid),
  .status     (status)
);

// ----- bench/tb_adaptive_gain_control_law_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_gain_control_law_core
// Self-checking bench for the adaptive regulator gain unit. A directed table
// covers reset state, field extremes, coefficient saturation, zero error,
// zero reference and gain accept/reject; random control-loop traffic follows
// under several register settings. Every result beat is checked in order
// against a typed table result or the bench's Q16.16 gain law predictor.
// ----------------------------------------------------------------------------
module tb_adaptive_gain_control_law_core;
  import agcl_pkg::*;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_TEN = 32'sd655360;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam longint SUM_TOP = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int WAIT_MAX = 10;
  localparam int N_ROWS = 24;

  typedef struct packed {
    logic signed [31:0] gain;
    logic               valid;
    status_t            st;
  } gain_beat_t;

  typedef struct {
    func_t              op;
    logic signed [31:0] value;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    bit                 known;
    gain_beat_t         typed;
  } stim_row_t;

  localparam gain_beat_t NO_GAIN = '{GAIN_NONE, 1'b0, ST_NONE};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_stall;
  func_t                       func = FUNC_OUTPUT;
  logic signed [DATA_W-1:0]    sample_value = '0;
  logic signed [DATA_W-1:0]    est_p1 = '0;
  logic signed [DATA_W-1:0]    est_p2 = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  logic signed [DATA_W-1:0]    gain;
  logic                        gain_valid;
  logic [1:0]                  status;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  adaptive_gain_control_law_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .func(func), .sample_value(sample_value), .est_p1(est_p1), .est_p2(est_p2),
    .res_valid(res_valid), .res_stall(res_stall),
    .gain(gain), .gain_valid(gain_valid), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // gain law state
  longint m_ref, m_y, m_yprev, m_err, m_a1, m_a2, m_a3, m_gain;
  longint m_decay, m_band;
  bit     m_est_ok, m_gain_ok;

  gain_beat_t pending_gains[$];
  stim_row_t  directed_rows [N_ROWS];
  int         mismatches = 0;
  bit         calm = 1'b0;
  int         hold_left = 0;

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, WAIT_MAX));
  endfunction

  function automatic longint clamp32(longint x);
    if (x > longint'(Q_MAX)) return longint'(Q_MAX);
    if (x < longint'(Q_MIN)) return longint'(Q_MIN);
    return x;
  endfunction

  function automatic longint clamp_sum(logic signed [65:0] x);
    if (x > SUM_TOP) return SUM_TOP;
    if (x < -SUM_TOP) return -SUM_TOP;
    return longint'(x);
  endfunction

  function automatic status_t run_gain_rule();
    longint mag_e, mag_r, lhs, rhs, ed, diff, num, q;
    logic signed [65:0] wide;
    mag_e = (m_err < 0) ? -m_err : m_err;
    mag_r = (m_ref < 0) ? -m_ref : m_ref;
    lhs = (100 * mag_e) << FRAC_W;
    rhs = m_band * mag_r;
    if (lhs <= rhs) begin
      m_gain_ok = 1'b1;
      return ST_STEADY;
    end
    ed = (m_err * m_decay) >>> DECAY_W;
    diff = m_ref - ed;
    wide = m_a1 * diff;
    wide = wide + m_a2 * m_y;
    num = clamp_sum(wide);
    wide = num;
    wide = wide + m_a3 * m_yprev;
    num = clamp_sum(wide);
    q = clamp32(num / m_err);
    if (q < 0) begin
      m_gain_ok = 1'b0;
      return ST_REJECTED;
    end
    m_gain = q;
    m_gain_ok = 1'b1;
    return ST_NEW_GAIN;
  endfunction

  function automatic gain_beat_t compute_gain_law(func_t f, logic signed [31:0] v,
                                                  logic signed [31:0] p1,
                                                  logic signed [31:0] p2);
    gain_beat_t r;
    status_t    st;
    st = ST_NONE;
    case (f)
      FUNC_OUTPUT: begin
        m_yprev = m_y;
        m_y = v;
      end
      FUNC_REFERENCE: m_ref = v;
      FUNC_ERROR: begin
        m_err = v;
        if (m_est_ok) st = run_gain_rule();
      end
      default: begin
        m_a1 = clamp32(longint'(p1) + longint'(p2));
        m_a2 = clamp32(-(longint'(p1) + 2 * longint'(p2)));
        m_a3 = p2;
        m_est_ok = 1'b1;
      end
    endcase
    r.gain  = m_gain_ok ? 32'(m_gain) : GAIN_NONE;
    r.valid = m_gain_ok;
    r.st    = st;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_level();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
      4, 5: return 32'($signed($urandom_range(0, 4000 * 65536)) - 2000 * 65536);
      default: return $urandom;
    endcase
  endfunction

  // error a little either side of the steady band for the current reference
  function automatic logic signed [31:0] near_band_error();
    longint q;
    q = m_ref / longint'($urandom_range(30, 300));
    if ($urandom_range(0, 1) == 1) q = -q;
    return 32'(q);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_item(func_t f, logic signed [31:0] v, logic signed [31:0] p1,
                           logic signed [31:0] p2, bit known, gain_beat_t typed);
    gain_beat_t want;
    int         gap;
    func         <= f;
    sample_value <= v;
    est_p1       <= p1;
    est_p2       <= p2;
    item_valid   <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    want = compute_gain_law(f, v, p1, p2);
    pending_gains.push_back(known ? typed : want);
    gap = draw_wait();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_item();
    func_t              f;
    logic signed [31:0] v, p1, p2;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) f = FUNC_OUTPUT;
    else if (pick < 40) f = FUNC_REFERENCE;
    else if (pick < 85) f = FUNC_ERROR;
    else f = FUNC_ESTIMATE;
    v = rand_level();
    if (f == FUNC_ERROR && $urandom_range(0, 2) == 0) v = near_band_error();
    if (f == FUNC_ESTIMATE) begin
      p1 = rand_level();
      p2 = rand_level();
    end else begin
      p1 = $urandom;
      p2 = $urandom;
    end
    send_item(f, v, p1, p2, 1'b0, NO_GAIN);
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DECAY) m_decay = longint'(data[DECAY_W-1:0]);
    else if (idx == CFG_MAXERR) m_band = longint'(data);
  endtask

  always @(posedge clk) begin : result_check
    gain_beat_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_gains.size() == 0) begin
        report_mismatch("result beat with nothing pending, gain", gain, 0);
      end else begin
        want = pending_gains.pop_front();
        if (gain !== want.gain) report_mismatch("gain", gain, want.gain);
        if (gain_valid !== want.valid) report_mismatch("gain_valid", gain_valid, want.valid);
        if (status !== want.st) report_mismatch("status", status, want.st);
      end
    end
  end

  always @(posedge clk) begin : result_side
    int n;
    if (!rst && res_valid && !res_stall) begin
      n = draw_wait();
      hold_left <= n;
      res_stall <= (n != 0);
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      res_stall <= 1'b0;
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("tb_adaptive_gain_control_law_core: FAIL");
    $finish;
  end

  initial begin : stimulus
    int ph;
    m_ref = LEVEL_RESET;
    m_y = LEVEL_RESET;
    m_yprev = LEVEL_RESET;
    m_err = 0;
    m_a1 = 0;
    m_a2 = 0;
    m_a3 = 0;
    m_gain = GAIN_RESET;
    m_est_ok = 1'b0;
    m_gain_ok = 1'b0;
    m_decay = DECAY_RESET;
    m_band = MAXERR_RESET;

    directed_rows = '{
      // no estimate yet: error only stored
      '{FUNC_ERROR,     Q_ONE,  32'sd5, -32'sd5, 1'b1, NO_GAIN},
      '{FUNC_OUTPUT,    Q_MAX,  Q_MIN,  Q_MAX,   1'b1, NO_GAIN},
      '{FUNC_OUTPUT,    Q_MIN,  32'sd1, -32'sd1, 1'b1, NO_GAIN},
      '{FUNC_REFERENCE, Q_MIN,  Q_MAX,  Q_MIN,   1'b1, NO_GAIN},
      '{FUNC_REFERENCE, Q_MAX,  32'sd0, 32'sd0,  1'b1, NO_GAIN},
      // coefficients saturate
      '{FUNC_ESTIMATE,  32'sh5A5A5A5A, Q_MAX, Q_MAX, 1'b1, NO_GAIN},
      // zero error is always steady
      '{FUNC_ERROR,     32'sd0, Q_MIN,  Q_MIN,   1'b1, '{GAIN_RESET, 1'b1, ST_STEADY}},
      '{FUNC_REFERENCE, 32'sd0, 32'sd7, 32'sd9,  1'b1, '{GAIN_RESET, 1'b1, ST_NONE}},
      '{FUNC_ESTIMATE,  Q_MAX,  32'sd0, 32'sd0,  1'b1, '{GAIN_RESET, 1'b1, ST_NONE}},
      // zero reference, nonzero error, zero coefficients: gain of zero taken
      '{FUNC_ERROR,     Q_ONE,  Q_MAX,  Q_MIN,   1'b1, '{32'sd0, 1'b1, ST_NEW_GAIN}},
      '{FUNC_ESTIMATE,  32'sd0, Q_MIN,  Q_MIN,   1'b0, NO_GAIN},
      '{FUNC_ERROR,     Q_MAX,  32'sd3, 32'sd3,  1'b0, NO_GAIN},
      '{FUNC_ERROR,     Q_MIN,  32'sd0, 32'sd0,  1'b0, NO_GAIN},
      '{FUNC_ERROR,     -32'sd1, 32'sd0, 32'sd0, 1'b0, NO_GAIN},
      '{FUNC_REFERENCE, Q_TEN,  -32'sd1, 32'sd1, 1'b0, NO_GAIN},
      '{FUNC_OUTPUT,    Q_TEN,  32'sd0, 32'sd0,  1'b0, NO_GAIN},
      '{FUNC_OUTPUT,    Q_TEN,  32'sd0, 32'sd0,  1'b0, NO_GAIN},
      '{FUNC_ESTIMATE,  32'sd0, -Q_ONE, 32'sd0,  1'b0, NO_GAIN},
      '{FUNC_ERROR,     32'sd65, 32'sd0, 32'sd0, 1'b0, NO_GAIN},
      '{FUNC_ERROR,     32'sd131072, 32'sd0, 32'sd0, 1'b0, NO_GAIN},
      '{FUNC_ERROR,     -32'sd131072, 32'sd0, 32'sd0, 1'b0, NO_GAIN},
      '{FUNC_ESTIMATE,  32'sd0, Q_ONE,  32'sd0,  1'b0, NO_GAIN},
      '{FUNC_ERROR,     32'sd131072, 32'sd0, 32'sd0, 1'b0, NO_GAIN},
      '{FUNC_OUTPUT,    32'sd1, 32'sd0, 32'sd0,  1'b0, NO_GAIN}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++)
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].p1,
                directed_rows[i].p2, directed_rows[i].known, directed_rows[i].typed);

    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_DECAY, '0);
          write_reg(CFG_MAXERR, '0);
        end
        1: begin
          // bits above the decay width are dropped
          write_reg(CFG_DECAY, '1);
          write_reg(CFG_MAXERR, '1);
        end
        2: begin
          write_reg(CFG_MAXERR, CFG_DATA_W'(6553600));
          write_reg(CFG_DECAY, CFG_DATA_W'($urandom));
        end
        3: begin
          write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
          write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
          write_reg(CFG_DECAY, CFG_DATA_W'(DECAY_RESET));
          write_reg(CFG_MAXERR, MAXERR_RESET);
        end
        default: begin
          write_reg(CFG_DECAY, CFG_DATA_W'($urandom_range(0, 65535)));
          write_reg(CFG_MAXERR, CFG_DATA_W'($urandom_range(0, 327680)));
        end
      endcase
      cfg_valid <= 1'b0;
      calm = (ph % 3 == 2);
      repeat (80) random_item();
    end

    item_valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("tb_adaptive_gain_control_law_core: PASS");
    else
      $display("tb_adaptive_gain_control_law_core: FAIL");
    $finish;
  end

endmodule

// ----- adaptive_gain_control_law_core.f -----
hw/rtl/agcl_pkg.sv
hw/rtl/adaptive_gain_control_law_core.sv
hw/rtl/agcl_checker.sv
bench/tb_adaptive_gain_control_law_core.sv
